[hw/rtl/mbps_pkg.sv]
package mbps_pkg;

   localparam int MAX_PATTERN_DEFAULT = 16;
   localparam int PAT_BYTES = 16;
   localparam int ADDR_W = 64;
   localparam int SCAN_W = 32;
   localparam int PLEN_W = 5;
   localparam int WILD_W = 16;
   // holds any start offset below 2^32 plus the longest pattern
   localparam int COUNT_W = 33;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_BASE_ADDRESS = 3'd0;
   localparam csr_index_type CSR_SCAN_LENGTH = 3'd1;
   localparam csr_index_type CSR_PATTERN_LENGTH = 3'd2;
   localparam csr_index_type CSR_PATTERN_LO = 3'd3;
   localparam csr_index_type CSR_PATTERN_HI = 3'd4;
   localparam csr_index_type CSR_WILDCARD = 3'd5;

   // stage 1 item handed from the byte counter to the evaluator
   typedef struct packed {
      logic valid;
      logic last;
      logic [COUNT_W-1:0] seen;
   } stage1_type;

endpackage

[hw/rtl/mbps_cell.sv]
module mbps_cell (
   input  logic       clock,
   input  logic       shift_en,
   input  logic [7:0] byte_in,
   input  logic [7:0] pat_byte,
   input  logic       wild,
   output logic [7:0] byte_out,
   output logic       match_out
);

   logic [7:0] data_ff;
   logic [7:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (shift_en) begin
         data_in = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign byte_out = data_ff;
   // compare the held byte with the pattern byte for its current age
   assign match_out = wild | (data_ff == pat_byte);

endmodule

[hw/rtl/mbps_eval.sv]
module mbps_eval #(
   parameter int MaxPattern = mbps_pkg::MAX_PATTERN_DEFAULT,
   parameter int LenW = $clog2(MaxPattern + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  mbps_pkg::stage1_type          s1,
   input  logic                          window_match,
   input  logic [LenW-1:0]               eff_len,
   input  logic [mbps_pkg::SCAN_W-1:0]   scan_length,
   input  logic [mbps_pkg::ADDR_W-1:0]   base_address,
   output logic                          rsp_valid,
   output logic                          rsp_found,
   output logic [mbps_pkg::ADDR_W-1:0]   rsp_address
);

   logic                          done_ff, done_in;
   logic                          v2_ff, v2_in;
   logic                          found2_ff, found2_in;
   logic [mbps_pkg::COUNT_W-1:0]  pos2_ff, pos2_in;
   logic                          out_valid_ff, out_valid_in;
   logic                          out_found_ff, out_found_in;
   logic [mbps_pkg::ADDR_W-1:0]   out_addr_ff, out_addr_in;

   logic [mbps_pkg::COUNT_W-1:0]  len_ext;
   logic [mbps_pkg::COUNT_W-1:0]  pos;
   logic                          cand;
   logic                          hit;
   logic                          fail;

   always_comb begin
      len_ext = mbps_pkg::COUNT_W'(eff_len);
      pos = s1.seen - len_ext;
      cand = (s1.seen >= len_ext) && (pos < mbps_pkg::COUNT_W'(scan_length));
      hit = s1.valid && !done_ff && cand && window_match;
      fail = s1.valid && s1.last && !done_ff && !hit;

      done_in = done_ff;
      v2_in = v2_ff;
      found2_in = found2_ff;
      pos2_in = pos2_ff;
      out_valid_in = out_valid_ff;
      out_found_in = out_found_ff;
      out_addr_in = out_addr_ff;
      if (advance) begin
         if (s1.valid) begin
            // the last marker clears the search
            done_in = s1.last ? 1'b0 : (done_ff | hit);
         end
         v2_in = hit | fail;
         found2_in = hit;
         pos2_in = pos;
         out_valid_in = v2_ff;
         out_found_in = found2_ff;
         out_addr_in = found2_ff ?
            base_address + mbps_pkg::ADDR_W'(pos2_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
         v2_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
         v2_ff <= v2_in;
         out_valid_ff <= out_valid_in;
      end
      found2_ff <= found2_in;
      pos2_ff <= pos2_in;
      out_found_ff <= out_found_in;
      out_addr_ff <= out_addr_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_found = out_found_ff;
   assign rsp_address = out_addr_ff;

endmodule

[hw/rtl/masked_byte_pattern_scan_top.sv]
// Masked byte pattern scan.
// req_*: one byte of the scanned region per item, req_tlast on the final
// byte of the stream (the stream carries pattern_length - 1 bytes past the
// last candidate start). rsp_*: at most one item per stream: rsp_tuser is
// found, rsp_tdata the match address (base_address + offset) or 0.
// csr_*: register writes, index 0..5 = base_address, scan_length,
// pattern_length, pattern bytes 0..7, pattern bytes 8..15, wildcard bits;
// accepted every cycle. Write them only while no item is in flight.
// A row of MaxPattern cells holds the last bytes; each cell compares the
// byte it holds with the pattern byte aligned to its age, so one byte
// is taken every cycle while req_tready is high, a rate set by the cell
// row shift. After the item that completes the match (or the final byte)
// is accepted, the result passes the stage 1, v2 and output registers.
// Reset clears the search and loads the register defaults (scan_length 1,
// pattern_length 1, the others 0); no clearing pass is needed.
// When rsp_tready is low with a result held, the whole pipeline freezes
// and req_tready drops until the result is taken.
module masked_byte_pattern_scan_top #(
   parameter int MaxPattern = mbps_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // data_byte
   input  logic                                req_tlast,   // last_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mbps_pkg::ADDR_W-1:0]         rsp_tdata,   // match_address
   output logic                                rsp_tuser,   // found
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  mbps_pkg::csr_index_type             csr_index,
   input  logic [mbps_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int LenW = $clog2(MaxPattern + 1);

   logic [mbps_pkg::ADDR_W-1:0]         base_ff, base_in;
   logic [mbps_pkg::SCAN_W-1:0]         scan_ff, scan_in;
   logic [mbps_pkg::PLEN_W-1:0]         plen_ff, plen_in;
   logic [8*mbps_pkg::PAT_BYTES-1:0]    pat_ff, pat_in;
   logic [mbps_pkg::WILD_W-1:0]         wild_ff, wild_in;

   logic [mbps_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic [mbps_pkg::COUNT_W-1:0]        seen_new;
   mbps_pkg::stage1_type                s1_ff, s1_in;

   logic                                advance;
   logic                                accept;
   logic [LenW-1:0]                     eff_len;
   logic [7:0]                          al_byte [MaxPattern];
   logic [MaxPattern-1:0]               al_wild;
   logic [7:0]                          win [MaxPattern];
   logic [MaxPattern-1:0]               cell_match;
   logic                                window_match;

   assign csr_ready = 1'b1;

   // configuration registers
   always_comb begin
      base_in = base_ff;
      scan_in = scan_ff;
      plen_in = plen_ff;
      pat_in = pat_ff;
      wild_in = wild_ff;
      if (csr_valid) begin
         case (csr_index)
            mbps_pkg::CSR_BASE_ADDRESS: base_in = csr_data;
            mbps_pkg::CSR_SCAN_LENGTH: scan_in = csr_data[mbps_pkg::SCAN_W-1:0];
            mbps_pkg::CSR_PATTERN_LENGTH: plen_in = csr_data[mbps_pkg::PLEN_W-1:0];
            mbps_pkg::CSR_PATTERN_LO: pat_in[63:0] = csr_data;
            mbps_pkg::CSR_PATTERN_HI: pat_in[127:64] = csr_data;
            mbps_pkg::CSR_WILDCARD: wild_in = csr_data[mbps_pkg::WILD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         scan_ff <= mbps_pkg::SCAN_W'(1);
         plen_ff <= mbps_pkg::PLEN_W'(1);
         pat_ff <= '0;
         wild_ff <= '0;
      end else begin
         base_ff <= base_in;
         scan_ff <= scan_in;
         plen_ff <= plen_in;
         pat_ff <= pat_in;
         wild_ff <= wild_in;
      end
   end

   // clamp the pattern length to 1..MaxPattern
   always_comb begin
      if (plen_ff == '0) begin
         eff_len = LenW'(1);
      end else if (int'(plen_ff) > MaxPattern) begin
         eff_len = LenW'(MaxPattern);
      end else begin
         eff_len = LenW'(plen_ff);
      end
   end

   // pattern byte that a byte of age m must match: index len - 1 - m
   always_comb begin
      int idx;
      logic [3:0] sel;
      for (int m = 0; m < MaxPattern; m++) begin
         idx = int'(eff_len) - 1 - m;
         sel = idx[3:0];
         al_byte[m] = 8'h00;
         al_wild[m] = 1'b1;
         if (m < int'(eff_len)) begin
            al_wild[m] = 1'b0;
            if (idx < mbps_pkg::PAT_BYTES) begin
               al_byte[m] = pat_ff[8*sel +: 8];
               al_wild[m] = wild_ff[sel];
            end
         end
      end
   end

   assign advance = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign accept = req_tvalid && advance;

   for (genvar m = 0; m < MaxPattern; m++) begin : g_cell
      logic [7:0] byte_in;
      if (m == 0) begin : g_head
         assign byte_in = req_tdata;
      end else begin : g_link
         assign byte_in = win[m-1];
      end
      mbps_cell u_cell (
         .clock     (clock),
         .shift_en  (accept),
         .byte_in   (byte_in),
         .pat_byte  (al_byte[m]),
         .wild      (al_wild[m]),
         .byte_out  (win[m]),
         .match_out (cell_match[m])
      );
   end

   assign window_match = &cell_match;

   // count bytes of the current stream, saturating
   always_comb begin
      seen_new = (&count_ff) ? count_ff : count_ff + mbps_pkg::COUNT_W'(1);
      count_in = count_ff;
      s1_in = s1_ff;
      if (advance) begin
         s1_in.valid = req_tvalid;
         s1_in.last = req_tlast;
         s1_in.seen = seen_new;
         if (accept) begin
            count_in = req_tlast ? '0 : seen_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         s1_ff.valid <= 1'b0;
      end else begin
         count_ff <= count_in;
         s1_ff.valid <= s1_in.valid;
      end
      s1_ff.last <= s1_in.last;
      s1_ff.seen <= s1_in.seen;
   end

   mbps_eval #(
      .MaxPattern (MaxPattern),
      .LenW       (LenW)
   ) u_eval (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .s1           (s1_ff),
      .window_match (window_match),
      .eff_len      (eff_len),
      .scan_length  (scan_ff),
      .base_address (base_ff),
      .rsp_valid    (rsp_tvalid),
      .rsp_found    (rsp_tuser),
      .rsp_address  (rsp_tdata)
   );

endmodule
